[rtl/cartesian_to_radar_polar_defines.svh]
// assertion macros for the radar measurement block
`ifndef CARTESIAN_TO_RADAR_POLAR_DEFINES_SVH
`define CARTESIAN_TO_RADAR_POLAR_DEFINES_SVH
`define C2RP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbl failed");
`define C2RP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl failed");
`endif

[rtl/c2rp_pkg.sv]
// shared constants and tables for the radar measurement block
package c2rp_pkg;
   localparam int CordicStepsDefault = 16;
   localparam int FracBitsDefault = 16;
   localparam int GuardBits = 16;
   localparam int WordBits = 32;
   localparam int BearingBits = 19;
   localparam int AccBits = 34;
   localparam int CordicBits = 66;
   localparam int DivBits = 66;
   localparam logic signed [AccBits-1:0] PiQ30 = 34'sd3373259426;
   localparam logic [31:0] InvGainQ32 = 32'h9B74EDA8;

   function automatic logic signed [AccBits-1:0] atan_q30(input int idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'h3243F6A8; 1: t = 32'h1DAC6705; 2: t = 32'h0FADBAFC;
         3: t = 32'h07F56EA6; 4: t = 32'h03FEAB76; 5: t = 32'h01FFD55B;
         6: t = 32'h00FFFAAA; 7: t = 32'h007FFF55; 8: t = 32'h003FFFEA;
         9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
         12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
         15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
         18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
         21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
         24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
         27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
         30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return signed'({2'b00, t});
   endfunction
endpackage

[rtl/c2rp_cordic.sv]
// pipelined cordic vectoring unit, range scaling and bearing rounding
module c2rp_cordic #(
   parameter int CORDIC_STEPS = c2rp_pkg::CordicStepsDefault,
   parameter int FRAC_BITS = c2rp_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic adv,
   input  logic signed [31:0] px,
   input  logic signed [31:0] py,
   output logic [31:0] range_q,
   output logic [c2rp_pkg::BearingBits-1:0] bearing_q
);
   localparam int W = c2rp_pkg::CordicBits;
   localparam int A = c2rp_pkg::AccBits;
   localparam int N = CORDIC_STEPS;
   localparam int RS = 29 - FRAC_BITS;
   localparam int SH = 30 - FRAC_BITS;

   logic signed [W-1:0] x_ff [N+1];
   logic signed [W-1:0] y_ff [N+1];
   logic signed [A-1:0] z_ff [N+1];
   logic signed [W-1:0] x_in [N+1];
   logic signed [W-1:0] y_in [N+1];
   logic signed [A-1:0] z_in [N+1];
   logic signed [W-1:0] x0, y0;
   logic [63:0] hi_ff, lo_ff, hi_in, lo_in;
   logic signed [A-1:0] zr_ff, zr_in;
   logic [64:0] scaled;
   logic [48:0] rng;
   logic signed [A-1:0] brg, lim;

   always_comb begin
      x0 = W'(px) <<< c2rp_pkg::GuardBits;
      y0 = W'(py) <<< c2rp_pkg::GuardBits;
      x_in[0] = x0;
      y_in[0] = y0;
      z_in[0] = '0;
      if (px < 0) begin
         x_in[0] = -x0;
         y_in[0] = -y0;
         z_in[0] = (py > 0) ? c2rp_pkg::PiQ30 : -c2rp_pkg::PiQ30;
      end
      for (int i = 0; i < N; i++) begin
         if (y_ff[i] < 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - c2rp_pkg::atan_q30(i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + c2rp_pkg::atan_q30(i);
         end
      end
      hi_in = (x_ff[N] < 0) ? '0 : 64'(x_ff[N][63:32]) * 64'(c2rp_pkg::InvGainQ32);
      lo_in = (x_ff[N] < 0) ? '0 : 64'(x_ff[N][31:0]) * 64'(c2rp_pkg::InvGainQ32);
      zr_in = z_ff[N];
      scaled = 65'(hi_ff) + 65'(lo_ff[63:32]) + 65'(17'h08000);
      rng = scaled[64:16];
      if (rng > 49'hFFFFFFFF) range_q = 32'hFFFFFFFF;
      else if (rng == '0) range_q = 32'd1;
      else range_q = rng[31:0];
      brg = (zr_ff + (A'(1) <<< RS)) >>> SH;
      lim = (c2rp_pkg::PiQ30 + (A'(1) <<< RS)) >>> SH;
      if (brg > lim) brg = lim;
      if (brg < -lim) brg = -lim;
      bearing_q = brg[c2rp_pkg::BearingBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         zr_ff <= zr_in;
      end
   end
endmodule

[rtl/c2rp_divider.sv]
// pipelined restoring divider for the range rate, one quotient bit a stage
module c2rp_divider (
   input  logic clock,
   input  logic adv,
   input  logic [64:0] num,
   input  logic neg,
   input  logic [31:0] den,
   output logic [31:0] rate_q
);
   localparam int NB = 65;
   logic [NB-1:0] q_ff [NB+1];
   logic [32:0] r_ff [NB+1];
   logic [31:0] d_ff [NB+1];
   logic n_ff [NB+1];
   logic [NB-1:0] q_in [NB+1];
   logic [32:0] r_in [NB+1];
   logic [33:0] t;
   logic [64:0] q;

   always_comb begin
      q_in[0] = num;
      r_in[0] = '0;
      for (int i = 0; i < NB; i++) begin
         t = {r_ff[i], q_ff[i][NB-1]};
         q_in[i+1] = q_ff[i] << 1;
         if (t >= 34'(d_ff[i])) begin
            r_in[i+1] = 33'(t - 34'(d_ff[i]));
            q_in[i+1][0] = 1'b1;
         end else begin
            r_in[i+1] = t[32:0];
         end
      end
      q = q_ff[NB];
      if (n_ff[NB]) begin
         if (q > 65'h80000000) rate_q = 32'h80000000;
         else rate_q = 32'(65'd0 - q);
      end else if (q > 65'h7FFFFFFF) rate_q = 32'h7FFFFFFF;
      else rate_q = q[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff[0] <= q_in[0];
         r_ff[0] <= r_in[0];
         d_ff[0] <= den;
         n_ff[0] <= neg;
         for (int i = 1; i <= NB; i++) begin
            q_ff[i] <= q_in[i];
            r_ff[i] <= r_in[i];
            d_ff[i] <= d_ff[i-1];
            n_ff[i] <= n_ff[i-1];
         end
      end
   end
endmodule

[rtl/cartesian_to_radar_polar.sv]
// top level of the radar measurement block
//  channel | dir | tdata fields (low bit up)
//  req_    | in  | pos_x, pos_y, vel_x, vel_y (128 bits)
//  rsp_    | out | range_out, bearing_out, range_rate_out (88 bits incl 5 pad)
// one beat per cycle while the pipeline advances; a beat runs through the cordic
// stages, the product stage and the 65 divider stages
// the whole pipeline advances when the output register is free or taken
// reset clears only the valid bits
module cartesian_to_radar_polar #(
   parameter int CORDIC_STEPS = c2rp_pkg::CordicStepsDefault,
   parameter int FRAC_BITS = c2rp_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [127:0] req_tdata,  // pos_x, pos_y, vel_x, vel_y
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [87:0] rsp_tdata    // range_out, bearing_out, range_rate_out
);
   localparam int LAT = CORDIC_STEPS + 3;
   localparam int DLAT = 65;
   localparam int RLAT = DLAT + 2;
   logic adv;
   logic [LAT:0] v_ff, v_in;
   logic [DLAT-1:0] dv_ff;
   logic signed [31:0] px, py, vx, vy;
   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0] pxd_ff [LAT-2], pyd_ff [LAT-2], vxd_ff [LAT-2], vyd_ff [LAT-2];
   logic [31:0] range_q, rng_ff [RLAT];
   logic [c2rp_pkg::BearingBits-1:0] bearing_q, brg_ff [RLAT];
   logic signed [63:0] p1_ff, p2_ff;
   logic [31:0] rng_d_ff;
   logic [64:0] num;
   logic [63:0] m1, m2;
   logic neg;
   logic [31:0] rate_q;

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = dv_ff[DLAT-1];
   assign px = (req_tdata[31:0] == '0) ? 32'sd1 : req_tdata[31:0];
   assign py = (req_tdata[63:32] == '0) ? 32'sd1 : req_tdata[63:32];
   assign vx = req_tdata[95:64];
   assign vy = req_tdata[127:96];
   assign v_in = {v_ff[LAT-1:0], req_tvalid};

   c2rp_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock(clock), .adv(adv), .px(px), .py(py),
      .range_q(range_q), .bearing_q(bearing_q)
   );

   always_comb begin
      m1 = p1_ff[63] ? 64'(-p1_ff) : 64'(p1_ff);
      m2 = p2_ff[63] ? 64'(-p2_ff) : 64'(p2_ff);
      if (p1_ff[63] == p2_ff[63]) begin
         num = 65'(m1) + 65'(m2);
         neg = p1_ff[63];
      end else if (m1 >= m2) begin
         num = 65'(m1 - m2);
         neg = p1_ff[63];
      end else begin
         num = 65'(m2 - m1);
         neg = p2_ff[63];
      end
      num = num + 65'(rng_d_ff[31:1]);
   end

   c2rp_divider u_div (
      .clock(clock), .adv(adv), .num(num), .neg(neg), .den(rng_d_ff), .rate_q(rate_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         dv_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
         dv_ff <= {dv_ff[DLAT-2:0], v_ff[LAT]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxd_ff[0] <= px;
         pyd_ff[0] <= py;
         vxd_ff[0] <= vx;
         vyd_ff[0] <= vy;
         for (int i = 1; i < LAT - 2; i++) begin
            pxd_ff[i] <= pxd_ff[i-1];
            pyd_ff[i] <= pyd_ff[i-1];
            vxd_ff[i] <= vxd_ff[i-1];
            vyd_ff[i] <= vyd_ff[i-1];
         end
         pos_x_ff <= pxd_ff[LAT-3];
         pos_y_ff <= pyd_ff[LAT-3];
         vel_x_ff <= vxd_ff[LAT-3];
         vel_y_ff <= vyd_ff[LAT-3];
         p1_ff <= 64'(pos_x_ff) * 64'(vel_x_ff);
         p2_ff <= 64'(pos_y_ff) * 64'(vel_y_ff);
         rng_d_ff <= range_q;
         rng_ff[0] <= range_q;
         brg_ff[0] <= bearing_q;
         for (int i = 1; i < RLAT; i++) begin
            rng_ff[i] <= rng_ff[i-1];
            brg_ff[i] <= brg_ff[i-1];
         end
      end
   end

   assign rsp_tdata = {5'd0, rate_q, brg_ff[RLAT-1], rng_ff[RLAT-1]};
endmodule

[rtl/c2rp_checker.sv]
// port checker for the radar measurement block
`include "cartesian_to_radar_polar_defines.svh"
module c2rp_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [87:0] rsp_tdata
);
   `C2RP_ASSERT_NEXT(hold_rsp, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `C2RP_ASSERT_IMPL(ready_free, clock, reset, !rsp_tvalid, req_tready)
   `C2RP_ASSERT_IMPL(pad_zero, clock, reset, rsp_tvalid, rsp_tdata[87:83] == 5'd0)
   `C2RP_ASSERT_IMPL(range_nz, clock, reset, rsp_tvalid, rsp_tdata[31:0] != 32'd0)
endmodule

bind cartesian_to_radar_polar c2rp_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[sim/c2rp_checker.sv]
// checker for the radar measurement block: predicts each beat and compares results
module c2rp_scoreboard (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [127:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [87:0] rsp_tdata,
   output int fail_count,
   output int pending_count,
   output int result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] range_m;
      logic [18:0] bearing;
      logic [31:0] range_rate;
   } radar_meas_type;

   localparam int Steps = c2rp_pkg::CordicStepsDefault;
   localparam int Frac = c2rp_pkg::FracBitsDefault;
   localparam int Guard = c2rp_pkg::GuardBits;
   localparam longint PiQ30 = 64'sd3373259426;
   localparam longint unsigned InvGain = 64'd2608131496;

   radar_meas_type expected_meas[$];

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic radar_meas_type measure_target(logic [127:0] beat);
      longint px, py, vx, vy, x, y, z, xs, ys, brg, lim, p1, p2;
      longint unsigned ux, scaled, rng, m1, m2, mag, q;
      logic neg1, neg2, neg;
      radar_meas_type m;
      px = longint'(signed'(beat[31:0]));
      py = longint'(signed'(beat[63:32]));
      vx = longint'(signed'(beat[95:64]));
      vy = longint'(signed'(beat[127:96]));
      if (px == 0) px = 1;
      if (py == 0) py = 1;
      x = px <<< Guard;
      y = py <<< Guard;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = (py > 0) ? PiQ30 : -PiQ30;
      end
      for (int i = 0; i < Steps && i < 32; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y < 0) begin
            x -= ys; y += xs; z -= longint'(c2rp_pkg::atan_q30(i));
         end else begin
            x += ys; y -= xs; z += longint'(c2rp_pkg::atan_q30(i));
         end
      end
      ux = (x < 0) ? 0 : longint'(x);
      scaled = (ux >> 32) * InvGain + (((ux & 64'hFFFFFFFF) * InvGain) >> 32);
      rng = (scaled + (64'd1 << (Guard - 1))) >> Guard;
      if (rng > 64'hFFFFFFFF) rng = 64'hFFFFFFFF;
      if (rng == 0) rng = 1;
      brg = floor_shift(z + (64'sd1 << (29 - Frac)), 30 - Frac);
      lim = floor_shift(PiQ30 + (64'sd1 << (29 - Frac)), 30 - Frac);
      if (brg > lim) brg = lim;
      if (brg < -lim) brg = -lim;
      p1 = px * vx;
      p2 = py * vy;
      neg1 = p1 < 0;
      neg2 = p2 < 0;
      m1 = neg1 ? 64'd0 - p1 : p1;
      m2 = neg2 ? 64'd0 - p2 : p2;
      if (neg1 == neg2) begin
         mag = m1 + m2; neg = neg1;
      end else if (m1 >= m2) begin
         mag = m1 - m2; neg = neg1;
      end else begin
         mag = m2 - m1; neg = neg2;
      end
      q = (mag + (rng >> 1)) / rng;
      if (neg) begin
         if (q > 64'h80000000) q = 64'h80000000;
         q = 64'd0 - q;
      end else if (q > 64'h7FFFFFFF) begin
         q = 64'h7FFFFFFF;
      end
      m.range_m = rng[31:0];
      m.bearing = brg[18:0];
      m.range_rate = q[31:0];
      return m;
   endfunction

   always @(posedge clock) begin
      radar_meas_type exp_m;
      radar_meas_type got;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_meas.push_back(measure_target(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.range_m = rsp_tdata[31:0];
            got.bearing = rsp_tdata[50:32];
            got.range_rate = rsp_tdata[82:51];
            result_count <= result_count + 1;
            if (expected_meas.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_m = expected_meas.pop_front();
               if (got != exp_m) begin
                  if (fail_count < 10)
                     $display("mismatch range %h/%h bearing %h/%h rate %h/%h (exp/got)",
                        exp_m.range_m, got.range_m, exp_m.bearing, got.bearing,
                        exp_m.range_rate, got.range_rate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_meas.size();
   end
endmodule

[sim/tb_cartesian_to_radar_polar.sv]
// testbench top for the radar measurement block: stimulus, idling and verdict
module tb_cartesian_to_radar_polar;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = c2rp_pkg::CordicStepsDefault + 69;
   localparam int WatchLimit = 4000;
   localparam int RandomBeats = 550;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   int fail_count, pending_count, result_count;
   int idle_cycles = 0;
   int sent_count = 0;
   logic [127:0] beats[$];
   logic quiet = 1'b0;

   always #2 clock = ~clock;

   cartesian_to_radar_polar i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   c2rp_scoreboard i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h0;
         3: return $urandom_range(0, 3) - 1;
         4: return 32'(signed'(16'($urandom)));
         5: return 32'(signed'(24'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [127:0] pack_state(logic [31:0] px, py, vx, vy);
      return {vy, vx, py, px};
   endfunction

   initial begin
      logic [31:0] ext[4];
      ext = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
      foreach (ext[a]) foreach (ext[b])
         beats.push_back(pack_state(ext[a], ext[b], ext[b], ext[a]));
      beats.push_back(pack_state(32'hFFFF0000, 32'h0, 32'h10000, 32'h0));
      beats.push_back(pack_state(32'hFFFF0000, 32'h1, 32'h0, 32'h0));
      beats.push_back(pack_state(32'hFFFF0000, 32'hFFFFFFFF, 32'h0, 32'h0));
      beats.push_back(pack_state(32'h0, 32'h0, 32'h0, 32'h0));
      beats.push_back(pack_state(32'h1, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF));
      beats.push_back(pack_state(32'h1, 32'h1, 32'h80000000, 32'h80000000));
      beats.push_back(pack_state(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      beats.push_back(pack_state(32'h00030000, 32'h00040000, 32'hFFFF0000, 32'h00020000));
      for (int i = 0; i < RandomBeats; i++)
         beats.push_back(pack_state(pick_coord(), pick_coord(), pick_coord(), pick_coord()));
   end

   // sender
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (beats.size() > 0) begin
         if (!quiet && $urandom_range(0, 9) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= beats.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent_count++;
         if (beats.size() < 80) quiet = 1'b1;
      end
      req_tvalid <= 1'b0;
   end

   // receiver
   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WatchLimit) begin
            $display("tb_cartesian_to_radar_polar NOT OK");
            $finish;
         end
      end
   end

   initial begin
      wait (!reset);
      wait (beats.size() == 0 && sent_count > 0 && !req_tvalid);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (Latency + 20) @(posedge clock);
      $display("covered %0d state beats incl. extremes, zero and left half-plane cases",
         sent_count);
      $display("%0d results checked, %0d failures", result_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_cartesian_to_radar_polar OK");
      end else begin
         $display("tb_cartesian_to_radar_polar NOT OK");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/c2rp_pkg.sv
rtl/c2rp_cordic.sv
rtl/c2rp_divider.sv
rtl/cartesian_to_radar_polar.sv
rtl/c2rp_checker.sv
sim/c2rp_checker.sv
sim/tb_cartesian_to_radar_polar.sv
